FILE: src/spds_pkg.sv
`default_nettype none
package spds_pkg;

   // Store and query buffer sizes.
   localparam int STORE_BYTES = 4096;
   localparam int MAX_LEN     = 256;

   // Widths; the address, fill and length widths follow from the sizes above.
   localparam int ADDR_W  = $clog2(STORE_BYTES);
   localparam int FILL_W  = $clog2(STORE_BYTES + 1);
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int ID_W    = 12;
   localparam int TOTAL_W = 12;
   localparam int CHAR_W  = 8;

   localparam logic [CHAR_W-1:0] NUL_CHAR = '0;

   // Request actions.
   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_FIND = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_FOUND    = 2'd0,
      STAT_APPENDED = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_TOO_LONG = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_RESP
   } state_type;

   // Controls broadcast to every cell of the query chain.
   typedef struct packed {
      logic shift;
      logic clear;
      logic step;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: src/spds_ram.sv
`default_nettype none
module spds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/spds_cell.sv
`default_nettype none
module spds_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire spds_pkg::cell_ctl_type      ctl,
   input  wire logic                        load,
   input  wire logic [spds_pkg::CHAR_W-1:0] char_in,
   input  wire logic [spds_pkg::CHAR_W-1:0] shift_in,
   input  wire logic                        match_in,
   input  wire logic [spds_pkg::CHAR_W-1:0] text,
   input  wire logic                        is_last,
   output logic      [spds_pkg::CHAR_W-1:0] char_out,
   output logic                             match_out,
   output logic                             hit
);
   import spds_pkg::*;

   logic [CHAR_W-1:0] char_ff;
   logic              match_ff;

   // Query character: written when it arrives, shifted toward cell 0 on append.
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
      end else if (ctl.shift) begin
         char_ff <= shift_in;
      end
   end

   // The prefix up to this cell matched the store ending at the current byte.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         match_ff <= 1'b0;
      end else if (ctl.step) begin
         match_ff <= match_in && (text == char_ff);
      end
   end

   // The last query cell matched one byte ago and the store now shows the NUL.
   assign hit       = match_ff && is_last && (text == NUL_CHAR);
   assign char_out  = char_ff;
   assign match_out = match_ff;

endmodule
`default_nettype wire

FILE: src/string_pool_dedup_store.sv
`default_nettype none
// String pool with suffix sharing. Characters arrive one per transfer on the
// req_ channel and are held in a chain of query cells; a zero character ends
// the string. Each character transfer gives no result. The
// terminator starts a walk of the store through one RAM read port, one byte a
// cycle, with every query cell comparing the byte in parallel and passing its
// match flag to the next cell. An add that finds no match and fits appends the string
// through the single write port. A result waits in the rsp_ output register
// while the next string's characters are already taken.
module string_pool_dedup_store (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_action,
   input  wire logic [spds_pkg::CHAR_W-1:0]  req_char_byte,
   input  wire logic [spds_pkg::ADDR_W-1:0]  req_search_start,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [spds_pkg::ID_W-1:0]    rsp_string_id,
   output logic      [1:0]                   rsp_status,
   output logic      [spds_pkg::TOTAL_W-1:0] rsp_string_total
);
   import spds_pkg::*;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [FILL_W-1:0]  addr_ff, addr_in;
   logic               rd_pend_ff;
   logic [ADDR_W-1:0]  pos_ff;
   logic               action_ff, action_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [ID_W-1:0]    res_id_ff, res_id_in;
   status_type         res_stat_ff, res_stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_id_ff;
   logic [1:0]         rsp_stat_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   logic               req_xfer, char_wr, term_xfer;
   logic               issue, hit, scan_done, rsp_load, append_last, too_big;
   logic [CHAR_W-1:0]  rd_data, text;
   cell_ctl_type       ctl;

   logic [CHAR_W-1:0]  cell_char [MAX_LEN];
   logic               cell_match [MAX_LEN];
   logic [MAX_LEN-1:0] cell_hit;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign term_xfer = req_xfer && (req_char_byte == NUL_CHAR);
   assign char_wr   = req_xfer && (req_char_byte != NUL_CHAR)
                      && (len_ff < LEN_W'(MAX_LEN));

   // Store walk: issue reads while below the fill, stop at the first hit.
   assign text      = (pos_ff == '0) ? NUL_CHAR : rd_data;
   assign hit       = rd_pend_ff && (|cell_hit);
   assign issue     = (state_ff == ST_SCAN) && !hit && (addr_ff < fill_ff);
   assign scan_done = (state_ff == ST_SCAN) && !hit && !issue && !rd_pend_ff;
   assign too_big   = ({1'b0, fill_ff} + (FILL_W + 1)'(len_ff) + (FILL_W + 1)'(1))
                      > (FILL_W + 1)'(STORE_BYTES);
   assign append_last = (state_ff == ST_APPEND) && (cnt_ff == len_ff);
   assign rsp_load    = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   assign ctl.shift = (state_ff == ST_APPEND);
   assign ctl.clear = term_xfer;
   assign ctl.step  = (state_ff == ST_SCAN) && rd_pend_ff;

   spds_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (state_ff == ST_APPEND),
      .wr_addr (ADDR_W'(fill_ff + FILL_W'(cnt_ff))),
      .wr_data (append_last ? NUL_CHAR : cell_char[0]),
      .rd_en   (issue),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Chain of query cells; match flags move one cell per store byte.
   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      logic [CHAR_W-1:0] shift_src;
      logic              match_src;
      if (k == MAX_LEN - 1) begin : g_end
         assign shift_src = NUL_CHAR;
      end else begin : g_mid
         assign shift_src = cell_char[k+1];
      end
      if (k == 0) begin : g_head
         assign match_src = 1'b1;
      end else begin : g_body
         assign match_src = cell_match[k-1];
      end
      spds_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .load      (char_wr && (len_ff == LEN_W'(k))),
         .char_in   (req_char_byte),
         .shift_in  (shift_src),
         .match_in  (match_src),
         .text      (text),
         .is_last   (len_ff == LEN_W'(k + 1)),
         .char_out  (cell_char[k]),
         .match_out (cell_match[k]),
         .hit       (cell_hit[k])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (term_xfer) begin
               state_in = (ovf_ff || len_ff == '0) ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_RESP;
            end else if (scan_done) begin
               state_in = (action_ff == ACT_FIND || too_big) ? ST_RESP : ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (append_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and results.
   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      addr_in      = addr_ff;
      action_in    = action_ff;
      cnt_in       = cnt_ff;
      res_id_in    = res_id_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (char_wr) begin
               len_in = len_ff + LEN_W'(1);
            end else if (req_xfer && !term_xfer) begin
               ovf_in = 1'b1;
            end
            if (term_xfer) begin
               action_in   = req_action;
               addr_in     = (req_action == ACT_FIND) ? FILL_W'(req_search_start) : '0;
               res_id_in   = '0;
               res_stat_in = ovf_ff ? STAT_TOO_LONG : STAT_FOUND;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + FILL_W'(1);
            end
            if (hit) begin
               res_id_in   = ID_W'(pos_ff - ADDR_W'(len_ff));
               res_stat_in = STAT_FOUND;
            end else if (scan_done) begin
               cnt_in      = '0;
               res_id_in   = '0;
               res_stat_in = (action_ff == ACT_ADD && too_big) ? STAT_FULL : STAT_FOUND;
            end
         end
         ST_APPEND: begin
            cnt_in = cnt_ff + LEN_W'(1);
            if (append_last) begin
               fill_in     = fill_ff + FILL_W'(len_ff) + FILL_W'(1);
               total_in    = total_ff + TOTAL_W'(1);
               res_id_in   = ID_W'(fill_ff);
               res_stat_in = STAT_APPENDED;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               len_in       = '0;
               ovf_in       = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         fill_ff      <= FILL_W'(1);
         total_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rd_pend_ff   <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      action_ff   <= action_in;
      cnt_ff      <= cnt_in;
      res_id_ff   <= res_id_in;
      res_stat_ff <= res_stat_in;
      if (issue) begin
         pos_ff <= addr_ff[ADDR_W-1:0];
      end
      if (rsp_load) begin
         rsp_id_ff    <= res_id_ff;
         rsp_stat_ff  <= res_stat_ff;
         rsp_total_ff <= total_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_string_id    = rsp_id_ff;
   assign rsp_status       = rsp_stat_ff;
   assign rsp_string_total = rsp_total_ff;

   // A walk only runs for a non-empty, non-overflowed query.
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> len_ff != '0 && !ovf_ff)
      else $error("store walk with empty or overflowed query");

   // An append always fits in the store.
   a_append_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPEND |-> !too_big)
      else $error("append beyond store size");

   // A terminator always leaves the idle state.
   a_term_leaves: assert property (@(posedge clock) disable iff (reset)
      term_xfer |=> state_ff != ST_IDLE)
      else $error("terminator transfer ignored");

   // The fill never drops to zero, keeping byte 0 reserved.
   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      fill_ff != '0)
      else $error("store fill reached zero");

endmodule
`default_nettype wire
